// ===== hdl/uart_rb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UART ring buffer package
// Transaction types, event codes and status codes shared by the ring buffer.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  typedef enum logic [1:0] {
    OP_LINE_RX  = 2'd0,
    OP_TX_READY = 2'd1,
    OP_GET      = 2'd2,
    OP_PUT      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } event_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
    logic       tx_irq_enabled;
    logic       rx_empty;
    logic       tx_full;
  } result_item_t;

endpackage
`default_nettype wire

// ===== hdl/uart_rx_tx_ring_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// A pair of byte rings between a UART and a processor, one event per
// transaction, one result transaction per event.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload          Handshake
//   event     in         event_item_t     event_valid / event_stall
//   result    out        result_item_t    result_valid / result_stall
//
// One event is accepted in every cycle while the result side keeps up; its
// result passes through the registered read port of the byte stores and the
// middle stage, and then through the output register.
// Reset (rst, synchronous) empties both rings and clears the transmit-interrupt
// enable. The byte stores are not cleared; only written entries are ever read.
// A stall on the result side holds the output register; event_stall rises
// once the middle stage also holds an event.
//
module uart_rx_tx_ring_buffer
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         event_valid,
  output logic              event_stall,
  input  wire event_item_t  event_data,
  output logic              result_valid,
  input  wire logic         result_stall,
  output result_item_t      result_data
);

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  // Byte stores. Each is written at one address and read at one address per
  // cycle, with the read data registered.
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd;
  logic [7:0] tx_rd;

  // Ring pointers and the transmit-interrupt enable.
  logic [RX_AW-1:0] rx_wp, rx_rp, rx_wp_next, rx_rp_next, rx_wp_inc, rx_rp_inc;
  logic [TX_AW-1:0] tx_wp, tx_rp, tx_wp_next, tx_rp_next, tx_wp_inc, tx_rp_inc;
  logic [TX_AW-1:0] tx_wp_next_inc;
  logic             tx_irq_en, tx_irq_en_next;

  // Middle stage: everything of the result but the byte, which comes from the
  // store read registers.
  typedef struct packed {
    logic       pop;
    logic       sel_tx;
    logic [1:0] status;
    logic       irq;
    logic       rx_empty;
    logic       tx_full;
  } mid_t;

  logic  mid_valid;
  mid_t  mid;
  mid_t  mid_next;
  logic  mid_adv;
  logic  ev_acc;

  logic rx_empty_now, rx_full_now, tx_empty_now, tx_full_now;
  logic rx_push, rx_pop, tx_push, tx_pop;

  assign mid_adv     = !result_valid || !result_stall;
  assign event_stall = mid_valid && !mid_adv;
  assign ev_acc      = event_valid && !event_stall;

  assign rx_wp_inc = (rx_wp == RX_LAST) ? '0 : rx_wp + 1'b1;
  assign rx_rp_inc = (rx_rp == RX_LAST) ? '0 : rx_rp + 1'b1;
  assign tx_wp_inc = (tx_wp == TX_LAST) ? '0 : tx_wp + 1'b1;
  assign tx_rp_inc = (tx_rp == TX_LAST) ? '0 : tx_rp + 1'b1;

  // The rings keep one slot empty: full when the write pointer would meet the
  // read pointer after one more push.
  assign rx_empty_now = (rx_wp == rx_rp);
  assign rx_full_now  = (rx_wp_inc == rx_rp);
  assign tx_empty_now = (tx_wp == tx_rp);
  assign tx_full_now  = (tx_wp_inc == tx_rp);

  always_comb begin
    rx_push        = 1'b0;
    rx_pop         = 1'b0;
    tx_push        = 1'b0;
    tx_pop         = 1'b0;
    tx_irq_en_next = tx_irq_en;
    mid_next       = '0;
    mid_next.status = ST_OK;
    unique case (event_data.opcode)
      OP_LINE_RX: begin
        if (rx_full_now) begin
          mid_next.status = ST_FULL;
        end else begin
          rx_push = 1'b1;
        end
      end
      OP_TX_READY: begin
        mid_next.sel_tx = 1'b1;
        if (tx_empty_now) begin
          tx_irq_en_next  = 1'b0;
          mid_next.status = ST_EMPTY;
        end else begin
          tx_pop       = 1'b1;
          mid_next.pop = 1'b1;
        end
      end
      OP_GET: begin
        if (rx_empty_now) begin
          mid_next.status = ST_EMPTY;
        end else begin
          rx_pop       = 1'b1;
          mid_next.pop = 1'b1;
        end
      end
      OP_PUT: begin
        if (tx_full_now) begin
          mid_next.status = ST_FULL;
        end else begin
          tx_push        = 1'b1;
          tx_irq_en_next = 1'b1;
        end
      end
      default: begin
        mid_next.status = ST_OK;
      end
    endcase

    rx_wp_next = rx_push ? rx_wp_inc : rx_wp;
    rx_rp_next = rx_pop  ? rx_rp_inc : rx_rp;
    tx_wp_next = tx_push ? tx_wp_inc : tx_wp;
    tx_rp_next = tx_pop  ? tx_rp_inc : tx_rp;
    tx_wp_next_inc = (tx_wp_next == TX_LAST) ? '0 : tx_wp_next + 1'b1;

    mid_next.irq      = tx_irq_en_next;
    mid_next.rx_empty = (rx_wp_next == rx_rp_next);
    mid_next.tx_full  = (tx_wp_next_inc == tx_rp_next);
  end

  // Ring state advances only on an accepted event.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp     <= '0;
      rx_rp     <= '0;
      tx_wp     <= '0;
      tx_rp     <= '0;
      tx_irq_en <= 1'b0;
    end else if (ev_acc) begin
      rx_wp     <= rx_wp_next;
      rx_rp     <= rx_rp_next;
      tx_wp     <= tx_wp_next;
      tx_rp     <= tx_rp_next;
      tx_irq_en <= tx_irq_en_next;
    end
  end

  // Store writes and registered reads. The read registers only move on an
  // accepted event, so they hold while the middle stage waits.
  always_ff @(posedge clk) begin
    if (ev_acc && rx_push) begin
      rx_mem[rx_wp] <= event_data.data_byte;
    end
    if (ev_acc && rx_pop) begin
      rx_rd <= rx_mem[rx_rp];
    end
  end

  always_ff @(posedge clk) begin
    if (ev_acc && tx_push) begin
      tx_mem[tx_wp] <= event_data.data_byte;
    end
    if (ev_acc && tx_pop) begin
      tx_rd <= tx_mem[tx_rp];
    end
  end

  // Middle stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (ev_acc) begin
      mid_valid <= 1'b1;
    end else if (mid_adv) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_acc) begin
      mid <= mid_next;
    end
  end

  // Output register. The byte is forced to zero when nothing was popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (mid_adv) begin
      result_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && mid_valid) begin
      result_data.out_byte       <= mid.pop ? (mid.sel_tx ? tx_rd : rx_rd) : 8'd0;
      result_data.out_valid      <= mid.pop;
      result_data.status         <= mid.status;
      result_data.tx_irq_enabled <= mid.irq;
      result_data.rx_empty       <= mid.rx_empty;
      result_data.tx_full        <= mid.tx_full;
    end
  end

  // A line byte that meets a full receive ring leaves the write pointer alone.
  a_rx_drop_keeps_ptr: assert property (@(posedge clk) disable iff (rst)
    ev_acc && event_data.opcode == OP_LINE_RX && rx_full_now |=> $stable(rx_wp))
    else $error("receive write pointer moved on a dropped byte");

  // An accepted put sets the transmit-interrupt enable.
  a_put_sets_irq: assert property (@(posedge clk) disable iff (rst)
    ev_acc && event_data.opcode == OP_PUT && !tx_full_now |=> tx_irq_en)
    else $error("transmit-interrupt enable not set by a put");

  // A popped byte always goes with an ok status.
  a_pop_status_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.out_valid |-> result_data.status == ST_OK)
    else $error("popped byte reported with a failing status");

  // No byte is shown when nothing was popped.
  a_no_pop_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.out_valid |-> result_data.out_byte == 8'd0)
    else $error("byte shown without a pop");

  // The middle stage never holds an item while the output is free to take it.
  a_mid_drains: assert property (@(posedge clk) disable iff (rst)
    mid_valid && !result_valid && !ev_acc |=> !mid_valid)
    else $error("middle stage failed to drain");

endmodule
`default_nettype wire
